// ----- hdl/piezo_note_trigger_unit_defines.svh -----
// Assertion macros shared by the trigger unit RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PIEZO_NOTE_TRIGGER_UNIT_DEFINES_SVH
`define PIEZO_NOTE_TRIGGER_UNIT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define PTU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PTU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ptu_pkg.sv -----
`default_nettype none

package ptu_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int TIME_BITS_DEF   = 32;

    localparam int THR_BITS       = 10;
    localparam int DIV_BITS       = 10;
    localparam int OUT_BITS       = 7;
    localparam int WAIT_BITS      = 20;
    localparam int CFG_DATA_BITS  = 20;
    localparam int CFG_INDEX_BITS = 3;

    localparam int WINDOW_US = 100;

    localparam logic [THR_BITS-1:0]  THRESHOLD_RST = THR_BITS'(80);
    localparam logic [DIV_BITS-1:0]  DIVIDER_RST   = DIV_BITS'(8);
    localparam logic [OUT_BITS-1:0]  OUT_LOW_RST   = OUT_BITS'(0);
    localparam logic [OUT_BITS-1:0]  OUT_HIGH_RST  = OUT_BITS'(127);
    localparam logic [WAIT_BITS-1:0] WAIT_RST      = WAIT_BITS'(10000);
    localparam logic [THR_BITS-1:0]  FLOOR_RST     = THR_BITS'(3);
    localparam logic [OUT_BITS-1:0]  NOTE_RST      = OUT_BITS'(0);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_VELOCITY_MODE = 3'd0,
        REG_THRESHOLD     = 3'd1,
        REG_SCALE_DIVIDER = 3'd2,
        REG_OUTPUT_LOW    = 3'd3,
        REG_OUTPUT_HIGH   = 3'd4,
        REG_WAIT_TIME     = 3'd5,
        REG_FLOOR_LEVEL   = 3'd6,
        REG_NOTE_NUMBER   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic                 velocity_mode;
        logic [THR_BITS-1:0]  threshold;
        logic [DIV_BITS-1:0]  scale_divider;
        logic [OUT_BITS-1:0]  output_low;
        logic [OUT_BITS-1:0]  output_high;
        logic [WAIT_BITS-1:0] wait_time_us;
        logic [THR_BITS-1:0]  floor_level;
        logic [OUT_BITS-1:0]  note_number;
    } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/piezo_note_trigger_unit.sv -----
// An accepted sample passes through ST_EVAL, ST_DIV and ST_DONE, which registers its result once
// the output is free; no new sample is taken before ST_IDLE. ST_DIV waits on the bit-serial divider
// that scales the velocity and aftertouch values, one quotient bit per cycle.
// A waiting result does not block the next sample until that sample's own result is ready.
// Reset (rst_n, asynchronous, active low) restores the control registers, the configuration
// and the trigger state to their defaults; the block is ready on the first cycle after reset.
`default_nettype none

`include "piezo_note_trigger_unit_defines.svh"

module piezo_note_trigger_unit #(
    parameter int SAMPLE_BITS = ptu_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = ptu_pkg::TIME_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [ptu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [ptu_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [SAMPLE_BITS-1:0]             sample,
    input  wire logic [TIME_BITS-1:0]               time_us,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    note_valid,
    output logic [ptu_pkg::OUT_BITS-1:0]            note_value,
    output logic [ptu_pkg::OUT_BITS-1:0]            note_id,
    output logic                                    aftertouch_valid,
    output logic [ptu_pkg::OUT_BITS-1:0]            aftertouch_value
);

    localparam int OB    = ptu_pkg::OUT_BITS;
    localparam int LVL_W = (SAMPLE_BITS > ptu_pkg::THR_BITS) ? SAMPLE_BITS : ptu_pkg::THR_BITS;
    localparam int TCW   = (TIME_BITS > ptu_pkg::WAIT_BITS) ? TIME_BITS : ptu_pkg::WAIT_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } state_t;

    ptu_pkg::cfg_t cfg;

    state_t                 state_reg;
    logic [SAMPLE_BITS-1:0] s_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic                   lockout_reg;
    logic                   held_reg;
    logic                   listening_reg;
    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [LVL_W-1:0]       trough_reg;
    logic [TIME_BITS-1:0]   mark_reg;
    logic [OB-1:0]          at_level_reg;
    logic                   at_live_reg;
    logic                   ev_reg;
    logic                   ev_div_reg;
    logic [OB-1:0]          ev_val_reg;
    logic                   at_div_reg;

    logic                   out_valid_reg;
    logic                   note_valid_reg;
    logic [OB-1:0]          note_value_reg;
    logic [OB-1:0]          note_id_reg;
    logic                   at_valid_reg;
    logic [OB-1:0]          at_value_reg;

    // Outcome of the decision step for the sample held in s_reg.
    logic                   lockout_next;
    logic                   held_next;
    logic                   listening_next;
    logic [SAMPLE_BITS-1:0] peak_next;
    logic [LVL_W-1:0]       trough_next;
    logic [TIME_BITS-1:0]   mark_next;
    logic [OB-1:0]          at_level_next;
    logic                   at_live_next;
    logic                   ev_next;
    logic                   ev_div_next;
    logic [OB-1:0]          ev_val_next;
    logic                   at_div_next;
    logic [SAMPLE_BITS-1:0] div_src;

    logic [TIME_BITS-1:0]   elapsed;
    logic [TCW-1:0]         elapsed_ext;
    logic [LVL_W-1:0]       s_lvl;
    logic [LVL_W-1:0]       thr_lvl;
    logic [LVL_W-1:0]       floor_lvl;
    logic [LVL_W-1:0]       peak_upd_lvl;
    logic [SAMPLE_BITS-1:0] peak_upd;
    logic [LVL_W-1:0]       trough_upd;
    logic                   rising;
    logic                   spike;

    logic                   div_start;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] quotient;
    logic [OB-1:0]          scaled_val;
    logic [OB-1:0]          at_level_fin;
    logic                   out_free;

    ptu_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ptu_divider #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_src),
        .divisor  (cfg.scale_divider),
        .done     (div_done),
        .quotient (quotient)
    );

    assign elapsed     = now_reg - mark_reg;
    assign elapsed_ext = TCW'(elapsed);
    assign s_lvl       = LVL_W'(s_reg);
    assign thr_lvl     = LVL_W'(cfg.threshold);
    assign floor_lvl   = LVL_W'(cfg.floor_level);

    assign rising       = s_reg > peak_reg;
    assign peak_upd     = rising ? s_reg : peak_reg;
    assign peak_upd_lvl = LVL_W'(peak_upd);
    assign trough_upd   = (!rising && (s_lvl < trough_reg) && !listening_reg) ? s_lvl
                                                                            : trough_reg;
    assign spike        = (peak_upd_lvl > trough_upd) &&
                          ((peak_upd_lvl - trough_upd) > thr_lvl);

    always_comb
    begin
        lockout_next   = lockout_reg;
        held_next      = held_reg;
        listening_next = listening_reg;
        peak_next      = peak_reg;
        trough_next    = trough_reg;
        mark_next      = mark_reg;
        at_level_next  = at_level_reg;
        at_live_next   = at_live_reg;
        ev_next        = 1'b0;
        ev_div_next    = 1'b0;
        ev_val_next    = cfg.output_low;
        at_div_next    = 1'b0;
        div_src        = s_reg;

        if (lockout_reg)
        begin
            if ((elapsed_ext > TCW'(cfg.wait_time_us)) && (s_lvl <= floor_lvl))
            begin
                lockout_next = 1'b0;
                mark_next    = now_reg;
            end
        end
        else if (cfg.velocity_mode)
        begin
            if (held_reg)
            begin
                if (s_lvl < thr_lvl)
                begin
                    ev_next       = 1'b1;
                    at_level_next = '0;
                    at_live_next  = 1'b1;
                    held_next     = 1'b0;
                    lockout_next  = 1'b1;
                    peak_next     = '0;
                    trough_next   = thr_lvl;
                    mark_next     = now_reg;
                end
                else
                begin
                    at_div_next  = 1'b1;
                    at_live_next = 1'b1;
                end
            end
            else
            begin
                at_live_next = 1'b0;
                peak_next    = peak_upd;
                trough_next  = trough_upd;
                div_src      = peak_upd;
                if (elapsed_ext >= TCW'(ptu_pkg::WINDOW_US))
                begin
                    if (listening_reg)
                    begin
                        ev_next        = 1'b1;
                        ev_div_next    = 1'b1;
                        held_next      = 1'b1;
                        listening_next = 1'b0;
                    end
                    else if (spike)
                    begin
                        listening_next = 1'b1;
                    end
                    else
                    begin
                        peak_next   = '0;
                        trough_next = thr_lvl;
                    end
                    mark_next = now_reg;
                end
            end
        end
        else
        begin
            if (!held_reg && (s_lvl > thr_lvl))
            begin
                ev_next     = 1'b1;
                ev_val_next = cfg.output_high;
                held_next   = 1'b1;
            end
            else if (held_reg && (s_lvl <= thr_lvl))
            begin
                ev_next      = 1'b1;
                held_next    = 1'b0;
                lockout_next = 1'b1;
                mark_next    = now_reg;
            end
        end
    end

    // Clamp of the quotient; with crossed bounds the lower bound wins below it.
    always_comb
    begin
        if (quotient < SAMPLE_BITS'(cfg.output_low))
        begin
            scaled_val = cfg.output_low;
        end
        else if (quotient > SAMPLE_BITS'(cfg.output_high))
        begin
            scaled_val = cfg.output_high;
        end
        else
        begin
            scaled_val = quotient[OB-1:0];
        end
    end

    assign at_level_fin = at_div_reg ? scaled_val : at_level_reg;
    assign div_start    = (state_reg == ST_EVAL);
    assign out_free     = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lockout_reg    <= 1'b0;
            held_reg       <= 1'b0;
            listening_reg  <= 1'b0;
            peak_reg       <= '0;
            trough_reg     <= LVL_W'(ptu_pkg::THRESHOLD_RST);
            mark_reg       <= '0;
            at_level_reg   <= '0;
            at_live_reg    <= 1'b1;
            ev_reg         <= 1'b0;
            ev_div_reg     <= 1'b0;
            at_div_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            note_valid_reg <= 1'b0;
            at_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !((state_reg == ST_DONE) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    lockout_reg   <= lockout_next;
                    held_reg      <= held_next;
                    listening_reg <= listening_next;
                    peak_reg      <= peak_next;
                    trough_reg    <= trough_next;
                    mark_reg      <= mark_next;
                    at_level_reg  <= at_level_next;
                    at_live_reg   <= at_live_next;
                    ev_reg        <= ev_next;
                    ev_div_reg    <= ev_div_next;
                    at_div_reg    <= at_div_next;
                    state_reg     <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        at_level_reg   <= at_level_fin;
                        out_valid_reg  <= 1'b1;
                        note_valid_reg <= ev_reg;
                        at_valid_reg   <= cfg.velocity_mode && held_reg && at_live_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            s_reg   <= sample;
            now_reg <= time_us;
        end
        if (state_reg == ST_EVAL)
        begin
            ev_val_reg <= ev_val_next;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            note_value_reg <= ev_reg ? (ev_div_reg ? scaled_val : ev_val_reg) : '0;
            note_id_reg    <= cfg.note_number;
            at_value_reg   <= (cfg.velocity_mode && held_reg && at_live_reg) ? at_level_fin
                                                                             : '0;
        end
    end

    assign in_ready         = (state_reg == ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign note_valid       = note_valid_reg;
    assign note_value       = note_value_reg;
    assign note_id          = note_id_reg;
    assign aftertouch_valid = at_valid_reg;
    assign aftertouch_value = at_value_reg;

    `PTU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    `PTU_ASSERT_NOW(a_lockout_released, lockout_reg, !held_reg, "note held during lockout")
    `PTU_ASSERT_NOW(a_quiet_value, out_valid && !note_valid, note_value == '0, "stray value")
    `PTU_ASSERT_NOW(a_quiet_touch, out_valid && !aftertouch_valid, aftertouch_value == '0, "stray touch")
    `PTU_ASSERT_NEXT(a_div_started, state_reg == ST_EVAL, state_reg == ST_DIV, "divider not started")

endmodule

`default_nettype wire

// ----- hdl/ptu_cfg_regs.sv -----
`default_nettype none

module ptu_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [ptu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [ptu_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output ptu_pkg::cfg_t                           cfg
);

    ptu_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.velocity_mode <= 1'b0;
            cfg_reg.threshold     <= ptu_pkg::THRESHOLD_RST;
            cfg_reg.scale_divider <= ptu_pkg::DIVIDER_RST;
            cfg_reg.output_low    <= ptu_pkg::OUT_LOW_RST;
            cfg_reg.output_high   <= ptu_pkg::OUT_HIGH_RST;
            cfg_reg.wait_time_us  <= ptu_pkg::WAIT_RST;
            cfg_reg.floor_level   <= ptu_pkg::FLOOR_RST;
            cfg_reg.note_number   <= ptu_pkg::NOTE_RST;
        end
        else if (cfg_write)
        begin
            unique case (ptu_pkg::cfg_reg_t'(cfg_index))
                ptu_pkg::REG_VELOCITY_MODE: cfg_reg.velocity_mode <= cfg_data[0];
                ptu_pkg::REG_THRESHOLD:
                    cfg_reg.threshold <= cfg_data[ptu_pkg::THR_BITS-1:0];
                ptu_pkg::REG_SCALE_DIVIDER:
                    cfg_reg.scale_divider <= cfg_data[ptu_pkg::DIV_BITS-1:0];
                ptu_pkg::REG_OUTPUT_LOW:
                    cfg_reg.output_low <= cfg_data[ptu_pkg::OUT_BITS-1:0];
                ptu_pkg::REG_OUTPUT_HIGH:
                    cfg_reg.output_high <= cfg_data[ptu_pkg::OUT_BITS-1:0];
                ptu_pkg::REG_WAIT_TIME:
                    cfg_reg.wait_time_us <= cfg_data[ptu_pkg::WAIT_BITS-1:0];
                ptu_pkg::REG_FLOOR_LEVEL:
                    cfg_reg.floor_level <= cfg_data[ptu_pkg::THR_BITS-1:0];
                ptu_pkg::REG_NOTE_NUMBER:
                    cfg_reg.note_number <= cfg_data[ptu_pkg::OUT_BITS-1:0];
                default: cfg_reg.velocity_mode <= cfg_reg.velocity_mode;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hdl/ptu_divider.sv -----
`default_nettype none

// Restoring divider: one quotient bit per cycle.
module ptu_divider #(
    parameter int SAMPLE_BITS = ptu_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [SAMPLE_BITS-1:0]       dividend,
    input  wire logic [ptu_pkg::DIV_BITS-1:0] divisor,
    output logic                              done,
    output logic [SAMPLE_BITS-1:0]            quotient
);

    localparam int DB = ptu_pkg::DIV_BITS;
    localparam int CW = $clog2(SAMPLE_BITS + 1);

    logic [SAMPLE_BITS-1:0] dvd_reg;
    logic [DB-1:0]          rem_reg;
    logic [DB-1:0]          dsr_reg;
    logic [CW-1:0]          count_reg;
    logic                   done_reg;

    logic [DB:0]            rem_shift;
    logic                   fits;
    logic [DB:0]            rem_diff;

    assign rem_shift = {rem_reg, dvd_reg[SAMPLE_BITS-1]};
    assign fits      = rem_shift >= {1'b0, dsr_reg};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                count_reg <= CW'(SAMPLE_BITS);
                done_reg  <= 1'b0;
            end
            else if (count_reg != '0)
            begin
                count_reg <= count_reg - 1'b1;
                done_reg  <= (count_reg == CW'(1));
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            // A divider of zero behaves as one.
            dsr_reg <= (divisor == '0) ? DB'(1) : divisor;
        end
        else if (count_reg != '0)
        begin
            // The remainder always stays below the divisor, so DB bits hold it.
            rem_reg <= fits ? rem_diff[DB-1:0] : rem_shift[DB-1:0];
            dvd_reg <= {dvd_reg[SAMPLE_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

// ----- bench/tb_piezo_note_trigger_unit.sv -----
`timescale 1ns / 1ps

module tb_piezo_note_trigger_unit;

    localparam int SB = ptu_pkg::SAMPLE_BITS_DEF;
    localparam int TB = ptu_pkg::TIME_BITS_DEF;
    localparam int WINDOW = ptu_pkg::WINDOW_US;
    localparam int OB = ptu_pkg::OUT_BITS;

    typedef struct packed {
        logic [SB-1:0] level;
        logic [TB-1:0] stamp;
    } sensor_reading_t;

    typedef struct packed {
        logic          note_valid;
        logic [OB-1:0] note_value;
        logic [OB-1:0] note_id;
        logic          touch_valid;
        logic [OB-1:0] touch_value;
    } note_event_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_write = 1'b0;
    ptu_pkg::cfg_reg_t                 cfg_index = ptu_pkg::REG_VELOCITY_MODE;
    logic [ptu_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [SB-1:0]                     sample = '0;
    logic [TB-1:0]                     time_us = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic                              note_valid;
    logic [OB-1:0]                     note_value;
    logic [OB-1:0]                     note_id;
    logic                              aftertouch_valid;
    logic [OB-1:0]                     aftertouch_value;

    piezo_note_trigger_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample           (sample),
        .time_us          (time_us),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .note_valid       (note_valid),
        .note_value       (note_value),
        .note_id          (note_id),
        .aftertouch_valid (aftertouch_valid),
        .aftertouch_value (aftertouch_value)
    );

    always #2 clk = ~clk;

    // Register copy and trigger state of the predictor.
    ptu_pkg::cfg_t cfg_now = '{velocity_mode: 1'b0, threshold: ptu_pkg::THRESHOLD_RST,
                               scale_divider: ptu_pkg::DIVIDER_RST,
                               output_low: ptu_pkg::OUT_LOW_RST,
                               output_high: ptu_pkg::OUT_HIGH_RST,
                               wait_time_us: ptu_pkg::WAIT_RST,
                               floor_level: ptu_pkg::FLOOR_RST,
                               note_number: ptu_pkg::NOTE_RST};
    logic          locked_out = 1'b0;
    logic          holding = 1'b0;
    logic          listening = 1'b0;
    logic [SB-1:0] peak_level = '0;
    logic [SB-1:0] trough_level = ptu_pkg::THRESHOLD_RST;
    logic [TB-1:0] window_mark = '0;
    logic [6:0]    pressure_level = '0;
    logic          pressure_live = 1'b1;

    sensor_reading_t samples_to_send[$];
    note_event_t     note_events_due[$];
    logic [TB-1:0]   stamp = '0;
    int              queued = 0;
    int              mismatches = 0;
    logic            steady_flow = 1'b0;
    int              send_gap = 0;
    int              recv_stall = 0;

    function automatic logic [OB-1:0] scale_level(logic [SB-1:0] v);
        logic [ptu_pkg::DIV_BITS-1:0] d;
        logic [SB-1:0]                q;
        d = (cfg_now.scale_divider == '0) ? ptu_pkg::DIV_BITS'(1) : cfg_now.scale_divider;
        q = v / d;
        // With crossed bounds the lower test wins, as in the clamp of the original.
        if (q < SB'(cfg_now.output_low))
            return cfg_now.output_low;
        if (q > SB'(cfg_now.output_high))
            return cfg_now.output_high;
        return q[OB-1:0];
    endfunction

    function automatic note_event_t predict_note_event(logic [SB-1:0] lvl, logic [TB-1:0] now);
        note_event_t   ev;
        logic [TB-1:0] elapsed;
        logic          fire;
        logic [OB-1:0] val;
        elapsed = now - window_mark;
        fire = 1'b0;
        val = '0;
        if (locked_out)
        begin
            if (elapsed > TB'(cfg_now.wait_time_us) && lvl <= cfg_now.floor_level)
            begin
                locked_out = 1'b0;
                window_mark = now;
            end
        end
        else if (cfg_now.velocity_mode)
        begin
            if (holding)
            begin
                if (lvl < cfg_now.threshold)
                begin
                    fire = 1'b1;
                    val = cfg_now.output_low;
                    pressure_level = '0;
                    pressure_live = 1'b1;
                    holding = 1'b0;
                    locked_out = 1'b1;
                    peak_level = '0;
                    trough_level = cfg_now.threshold;
                    window_mark = now;
                end
                else
                begin
                    pressure_level = scale_level(lvl);
                    pressure_live = 1'b1;
                end
            end
            else
            begin
                pressure_live = 1'b0;
                if (lvl > peak_level)
                    peak_level = lvl;
                else if (lvl < trough_level && !listening)
                    trough_level = lvl;
                if (elapsed >= TB'(WINDOW))
                begin
                    if (listening)
                    begin
                        fire = 1'b1;
                        val = scale_level(peak_level);
                        holding = 1'b1;
                        listening = 1'b0;
                    end
                    else if (peak_level > trough_level &&
                             peak_level - trough_level > cfg_now.threshold)
                        listening = 1'b1;
                    else
                    begin
                        peak_level = '0;
                        trough_level = cfg_now.threshold;
                    end
                    window_mark = now;
                end
            end
        end
        else
        begin
            if (!holding && lvl > cfg_now.threshold)
            begin
                fire = 1'b1;
                val = cfg_now.output_high;
                holding = 1'b1;
            end
            else if (holding && lvl <= cfg_now.threshold)
            begin
                fire = 1'b1;
                val = cfg_now.output_low;
                holding = 1'b0;
                locked_out = 1'b1;
                window_mark = now;
            end
        end
        ev.note_valid = fire;
        ev.note_value = fire ? val : '0;
        ev.note_id = cfg_now.note_number;
        ev.touch_valid = cfg_now.velocity_mode && holding && pressure_live;
        ev.touch_value = ev.touch_valid ? pressure_level : '0;
        return ev;
    endfunction

    function automatic int pick_pause();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic report_mismatch(string what, note_event_t want, note_event_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t %s: expected nv=%0d val=%0d id=%0d atv=%0d at=%0d,",
                      " got nv=%0d val=%0d id=%0d atv=%0d at=%0d"},
                     $realtime, what, want.note_valid, want.note_value, want.note_id,
                     want.touch_valid, want.touch_value, got.note_valid, got.note_value,
                     got.note_id, got.touch_valid, got.touch_value);
    endtask

    // Sender: a new sample is offered only once the previous one has been accepted.
    always @(posedge clk or negedge rst_n)
    begin
        sensor_reading_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                note_events_due.push_back(predict_note_event(sample, time_us));
            if (in_valid && !in_ready)
                ;
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (samples_to_send.size() != 0)
            begin
                r = samples_to_send.pop_front();
                in_valid <= 1'b1;
                sample <= r.level;
                time_us <= r.stamp;
                send_gap = pick_pause();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        note_event_t got;
        note_event_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.note_valid = note_valid;
                got.note_value = note_value;
                got.note_id = note_id;
                got.touch_valid = aftertouch_valid;
                got.touch_value = aftertouch_value;
                if (note_events_due.size() == 0)
                    report_mismatch("unexpected result", '0, got);
                else
                begin
                    want = note_events_due.pop_front();
                    if (got.note_valid !== want.note_valid ||
                        got.note_value !== want.note_value ||
                        got.note_id !== want.note_id ||
                        got.touch_valid !== want.touch_valid ||
                        got.touch_value !== want.touch_value)
                        report_mismatch("result mismatch", want, got);
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_stall = pick_pause();
            end
        end
    end

    task automatic send_reading(int unsigned lvl, int unsigned dt);
        sensor_reading_t r;
        stamp = stamp + TB'(dt);
        r.level = lvl[SB-1:0];
        r.stamp = stamp;
        samples_to_send.push_back(r);
        queued++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (samples_to_send.size() != 0 || in_valid || note_events_due.size() != 0);
    endtask

    task automatic write_register(ptu_pkg::cfg_reg_t idx, int unsigned value);
        logic [ptu_pkg::CFG_DATA_BITS-1:0] data;
        // Bits above the register's width carry junk; the block must ignore them.
        data = ptu_pkg::CFG_DATA_BITS'($urandom());
        case (idx)
            ptu_pkg::REG_VELOCITY_MODE:
            begin
                data[0] = value[0];
                cfg_now.velocity_mode = data[0];
            end
            ptu_pkg::REG_THRESHOLD:
            begin
                data[ptu_pkg::THR_BITS-1:0] = value[ptu_pkg::THR_BITS-1:0];
                cfg_now.threshold = data[ptu_pkg::THR_BITS-1:0];
            end
            ptu_pkg::REG_SCALE_DIVIDER:
            begin
                data[ptu_pkg::DIV_BITS-1:0] = value[ptu_pkg::DIV_BITS-1:0];
                cfg_now.scale_divider = data[ptu_pkg::DIV_BITS-1:0];
            end
            ptu_pkg::REG_OUTPUT_LOW:
            begin
                data[OB-1:0] = value[OB-1:0];
                cfg_now.output_low = data[OB-1:0];
            end
            ptu_pkg::REG_OUTPUT_HIGH:
            begin
                data[OB-1:0] = value[OB-1:0];
                cfg_now.output_high = data[OB-1:0];
            end
            ptu_pkg::REG_WAIT_TIME:
            begin
                data[ptu_pkg::WAIT_BITS-1:0] = value[ptu_pkg::WAIT_BITS-1:0];
                cfg_now.wait_time_us = data[ptu_pkg::WAIT_BITS-1:0];
            end
            ptu_pkg::REG_FLOOR_LEVEL:
            begin
                data[ptu_pkg::THR_BITS-1:0] = value[ptu_pkg::THR_BITS-1:0];
                cfg_now.floor_level = data[ptu_pkg::THR_BITS-1:0];
            end
            ptu_pkg::REG_NOTE_NUMBER:
            begin
                data[OB-1:0] = value[OB-1:0];
                cfg_now.note_number = data[OB-1:0];
            end
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
    endtask

    task automatic program_setting(int k);
        int unsigned mode, thr, dv, lo, hi, wt, flr, note;
        mode = $urandom_range(1, 0);
        thr = ($urandom_range(3, 0) == 0) ? $urandom_range(1023, 0) : $urandom_range(200, 0);
        dv = ($urandom_range(3, 0) == 0) ? $urandom_range(1023, 0) : $urandom_range(16, 0);
        lo = $urandom_range(40, 0);
        hi = $urandom_range(127, 60);
        wt = ($urandom_range(7, 0) == 0) ? $urandom_range(1048575, 0)
                                         : $urandom_range(2000, 0);
        flr = ($urandom_range(3, 0) == 0) ? $urandom_range(1023, 0) : $urandom_range(20, 0);
        note = $urandom_range(127, 0);
        case (k)
            0:
            begin
                mode = 0; thr = $urandom_range(600, 20); lo = 0; hi = 127; wt = 0;
            end
            1:
            begin
                mode = 1; thr = 80; dv = 8; lo = 0; hi = 127; wt = 200; flr = 3; note = 127;
            end
            2:
            begin
                mode = 1; thr = 0; dv = 1; lo = 0; hi = 127; wt = 0; flr = 0; note = 0;
            end
            3:
            begin
                mode = 1; thr = 1023; dv = 1023; lo = 127; hi = 127; wt = 1048575; flr = 1023;
            end
            4:
            begin
                // A divider of zero must behave as one.
                mode = 1; thr = $urandom_range(300, 20); dv = 0; lo = 10; hi = 100;
            end
            5:
            begin
                // Crossed clamp bounds.
                mode = 1; thr = $urandom_range(200, 20); dv = $urandom_range(8, 1);
                lo = 100; hi = 20;
            end
            6:
            begin
                mode = 0; thr = 0; flr = 1023;
            end
            7:
            begin
                mode = 0; thr = 1023;
            end
            default: ;
        endcase
        write_register(ptu_pkg::REG_VELOCITY_MODE, mode);
        write_register(ptu_pkg::REG_THRESHOLD, thr);
        write_register(ptu_pkg::REG_SCALE_DIVIDER, dv);
        write_register(ptu_pkg::REG_OUTPUT_LOW, lo);
        write_register(ptu_pkg::REG_OUTPUT_HIGH, hi);
        write_register(ptu_pkg::REG_WAIT_TIME, wt);
        write_register(ptu_pkg::REG_FLOOR_LEVEL, flr);
        write_register(ptu_pkg::REG_NOTE_NUMBER, note);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // One drum hit: rest at the floor, spike, hold, release, rearm.
    task automatic queue_strike();
        int unsigned thr, flr, pk, n, i;
        thr = cfg_now.threshold;
        flr = cfg_now.floor_level;
        n = $urandom_range(3, 1);
        for (i = 0; i < n; i++)
            send_reading($urandom_range(flr, 0), $urandom_range(60, 10));
        if ($urandom_range(9, 0) == 0 || thr >= 1023)
            pk = 1023;
        else
            pk = $urandom_range(1023, thr + 1);
        send_reading($urandom_range(pk, pk / 2), $urandom_range(30, 1));
        send_reading(pk, $urandom_range(30, 1));
        n = $urandom_range(6, 3);
        for (i = 0; i < n; i++)
            send_reading($urandom_range(pk, thr), $urandom_range(90, 25));
        send_reading((thr > 0) ? $urandom_range(thr - 1, 0) : 0, $urandom_range(80, 10));
        send_reading($urandom_range(flr, 0), $urandom_range(50, 1));
        send_reading($urandom_range(flr, 0), cfg_now.wait_time_us + $urandom_range(300, 1));
    endtask

    task automatic queue_noise();
        int unsigned n, i;
        n = $urandom_range(8, 2);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(19, 0) == 0)
                stamp = $urandom();
            send_reading($urandom_range(1023, 0), $urandom_range(300, 0));
        end
    endtask

    initial
    begin
        #4_000_000;
        $display("[piezo_note_trigger_unit] ERROR");
        $finish;
    end

    initial
    begin
        int phase;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // On/off behaviour at the reset settings, including a timestamp wrap
        // and a rearm that fails on the floor level before it succeeds.
        stamp = 32'hFFFF_FF00;
        send_reading(0, 0);
        send_reading(1023, 5);
        send_reading(81, 5);
        send_reading(80, 5);
        send_reading(0, 50);
        send_reading(3, 10000);
        send_reading(81, 5);
        send_reading(0, 5);
        send_reading(4, 10001);
        send_reading(3, 1);
        wait_drained();

        // Velocity mode from the same state: an empty window, a spike, the
        // delayed note-on, aftertouch, note-off and rearm.
        write_register(ptu_pkg::REG_VELOCITY_MODE, 1);
        @(posedge clk);
        cfg_write <= 1'b0;
        send_reading(0, 100);
        send_reading(0, 100);
        send_reading(1023, 10);
        send_reading(0, 10);
        send_reading(200, 100);
        send_reading(600, 100);
        send_reading(500, 20);
        send_reading(1023, 20);
        send_reading(79, 20);
        send_reading(0, 10001);

        for (phase = 0; phase < 12; phase++)
        begin
            // Every phase change waits until the last transaction has been checked.
            wait_drained();
            steady_flow = (phase % 4 == 3);
            program_setting(phase);
            queued = 0;
            while (queued < 125)
            begin
                if ($urandom_range(4, 0) == 0)
                    queue_noise();
                else
                    queue_strike();
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && note_events_due.size() == 0)
            $display("[piezo_note_trigger_unit] OK");
        else
            $display("[piezo_note_trigger_unit] ERROR");
        $finish;
    end

endmodule
